### sv/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the byte stream reassembler
// Ring size, index and count widths, command and status codes, the
// sequencer states and the request/response bundle of the offset unit.
// ----------------------------------------------------------------------------
package bsr_pkg;

	// Ring size in bytes. It is a power of two, so a slot is the low bits of an index.
	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int IDX_W    = 32;
	localparam int CNT_W    = 11;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam idx_t CAP_IDX = IDX_W'(CAPACITY);
	localparam slot_t SLOT_LAST = SLOT_W'(CAPACITY - 1);

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_NEW  = 2'd0,
		ST_DUP  = 2'd1,
		ST_DROP = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_P_WIN,
		S_P_END,
		S_P_OFF,
		S_P_CHK,
		S_P_EOF,
		S_P_EOFEND,
		S_R_POP,
		S_R_DATA,
		S_D_RD,
		S_D_CHK,
		S_DONE
	} state_t;

	// One request to the shared offset unit: diff = a - b, compared against lim.
	typedef struct packed {
		idx_t a;
		idx_t b;
		idx_t lim;
	} ofs_req_t;

	typedef struct packed {
		idx_t diff;
		logic lt;
		logic le;
	} ofs_res_t;

endpackage

### sv/bsr_ram.sv
// ----------------------------------------------------------------------------
// bsr_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/bsr_offset_unit.sv
// ----------------------------------------------------------------------------
// bsr_offset_unit: shared wrap-around offset and compare unit
// Forms a 32-bit modular offset a - b and compares it with a limit.
// ----------------------------------------------------------------------------
module bsr_offset_unit (
	input  bsr_pkg::ofs_req_t req,
	output bsr_pkg::ofs_res_t res
);
	import bsr_pkg::*;

	idx_t diff;

	always_comb begin
		diff     = req.a - req.b;
		res.diff = diff;
		res.lt   = diff < req.lim;
		res.le   = diff <= req.lim;
	end

endmodule

### sv/byte_stream_reassembler_core.sv
// ----------------------------------------------------------------------------
// byte_stream_reassembler_core: out-of-order byte stream reassembler
// Stores segment bytes by absolute index in a byte ring and hands them
// back in stream order once they have become contiguous.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one item per handshake: a
// push of one segment byte (or an empty segment end) or a read of one
// assembled byte. The output channel (out_valid / out_stall) returns exactly
// one result item per input item, in order.
// Every item is worked through by a small sequencer around one shared
// offset/compare unit, and in_stall stays high until the item is finished.
// A push runs its window checks, then the end-of-stream checks when it
// carries an end of stream, then the walk; a read pops a byte if one is
// assembled and fetches it, else goes straight to the walk. In the walk
// the expected index steps over the slots that have become contiguous,
// one slot per cycle through the valid-mark memory. The four window checks
// of a push share the offset unit, one check per cycle.
// The next item can be accepted in the cycle after a result is loaded.
// After reset the block clears its CAPACITY valid marks, one per cycle,
// with in_stall high; then it takes items.
// A finished result sits in the output register. The next item can be
// accepted while it waits; if the receiver still stalls when that item is
// done, the sequencer holds it until the register is free.
// ----------------------------------------------------------------------------
module byte_stream_reassembler_core (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  bsr_pkg::idx_t      stream_index,
	input  logic [7:0]         data_byte,
	input  logic               byte_present,
	input  logic               last_of_segment,
	input  logic               eof_flag,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         byte_status,
	output logic [7:0]         read_byte,
	output logic               read_valid,
	output bsr_pkg::idx_t      next_expected,
	output bsr_pkg::cnt_t      unassembled_count,
	output logic               stream_ended
);
	import bsr_pkg::*;

	// Sequencer.
	state_t state_q, nxt_state;

	// Stream bookkeeping. rlim_q always equals read_q + CAPACITY.
	idx_t  read_q, expect_q, rlim_q, end_q;
	logic  end_known_q;
	cnt_t  held_q;
	slot_t clr_q;

	// Captured item.
	idx_t       idx_q, seg_end_q;
	logic [7:0] data_q;
	logic       present_q, last_q, eof_q;

	// Intermediate results of the window checks.
	idx_t win_q, endoff_q;
	logic inwin_q, eof_ok_q;

	// Result being built, and the output register.
	status_t    status_q;
	logic [7:0] rbyte_q;
	logic       rvalid_q;
	logic       out_valid_q;
	status_t    out_status_q;
	logic [7:0] out_rbyte_q;
	logic       out_rvalid_q;
	idx_t       out_expect_q;
	cnt_t       out_held_q;
	logic       out_ended_q;

	// Memories.
	logic       vld_we, vld_wdata, vld_rdata;
	slot_t      vld_waddr, vld_raddr;
	logic       ring_we;
	logic [7:0] ring_rdata;

	// Shared unit.
	ofs_req_t ofs_req;
	ofs_res_t ofs_res;

	// Per-cycle decisions.
	logic    accept, do_store, do_pop, do_step, do_set_end, do_load, in_range, step_ok;
	status_t chk_status;

	bsr_offset_unit u_ofs (
		.req (ofs_req),
		.res (ofs_res)
	);

	// Valid marks of the ring slots.
	bsr_ram #(
		.WIDTH (1),
		.DEPTH (CAPACITY)
	) u_vld_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wdata),
		.raddr (vld_raddr),
		.rdata (vld_rdata)
	);

	// Byte ring. Only assembled slots are ever read back.
	bsr_ram #(
		.WIDTH (8),
		.DEPTH (CAPACITY)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (idx_q[SLOT_W-1:0]),
		.wdata (data_q),
		.raddr (read_q[SLOT_W-1:0]),
		.rdata (ring_rdata)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// A slot may be walked over while it lies inside the window, before a
	// known end, and holds a valid byte.
	assign step_ok = (expect_q != rlim_q) && !(end_known_q && (expect_q == end_q)) && vld_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= nxt_state;
		end
	end

	always_comb begin
		nxt_state   = state_q;
		vld_we      = 1'b0;
		vld_waddr   = idx_q[SLOT_W-1:0];
		vld_wdata   = 1'b0;
		vld_raddr   = idx_q[SLOT_W-1:0];
		ring_we     = 1'b0;
		ofs_req.a   = idx_q;
		ofs_req.b   = expect_q;
		ofs_req.lim = win_q;
		do_store    = 1'b0;
		do_pop      = 1'b0;
		do_step     = 1'b0;
		do_set_end  = 1'b0;
		do_load     = 1'b0;
		in_range    = 1'b0;
		chk_status  = ST_NONE;

		unique case (state_q)
			S_CLEAR: begin
				vld_we    = 1'b1;
				vld_waddr = clr_q;
				if (clr_q == SLOT_LAST) begin
					nxt_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					nxt_state = (command == CMD_READ) ? S_R_POP : S_P_WIN;
				end
			end
			S_P_WIN: begin
				ofs_req.a = rlim_q;
				nxt_state = S_P_END;
			end
			S_P_END: begin
				ofs_req.a = end_q;
				nxt_state = S_P_OFF;
			end
			S_P_OFF: begin
				nxt_state = S_P_CHK;
			end
			S_P_CHK: begin
				ofs_req.lim = endoff_q;
				in_range    = inwin_q && (!end_known_q || ofs_res.lt);
				if (!present_q) begin
					chk_status = ST_NONE;
				end else if (!in_range) begin
					chk_status = ST_DROP;
				end else if (vld_rdata) begin
					chk_status = ST_DUP;
				end else begin
					chk_status = ST_NEW;
					do_store   = 1'b1;
					vld_we     = 1'b1;
					vld_wdata  = 1'b1;
					ring_we    = 1'b1;
				end
				nxt_state = (last_q && eof_q) ? S_P_EOF : S_D_RD;
			end
			S_P_EOF: begin
				ofs_req.a = seg_end_q;
				nxt_state = S_P_EOFEND;
			end
			S_P_EOFEND: begin
				ofs_req.a   = seg_end_q;
				ofs_req.lim = endoff_q;
				do_set_end  = eof_ok_q && (!end_known_q || ofs_res.lt);
				nxt_state   = S_D_RD;
			end
			S_R_POP: begin
				if (read_q != expect_q) begin
					do_pop    = 1'b1;
					vld_we    = 1'b1;
					vld_waddr = read_q[SLOT_W-1:0];
					nxt_state = S_R_DATA;
				end else begin
					nxt_state = S_D_RD;
				end
			end
			S_R_DATA: begin
				nxt_state = S_D_RD;
			end
			S_D_RD: begin
				vld_raddr = expect_q[SLOT_W-1:0];
				nxt_state = S_D_CHK;
			end
			S_D_CHK: begin
				// Look one slot ahead so that the walk takes one slot per cycle.
				vld_raddr = expect_q[SLOT_W-1:0] + 1'b1;
				if (step_ok) begin
					do_step = 1'b1;
				end else begin
					nxt_state = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					do_load   = 1'b1;
					nxt_state = S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q      <= '0;
			expect_q    <= '0;
			rlim_q      <= CAP_IDX;
			held_q      <= '0;
			end_q       <= '0;
			end_known_q <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (do_pop) begin
				read_q <= read_q + 1'b1;
				rlim_q <= rlim_q + 1'b1;
			end
			if (do_store) begin
				held_q <= held_q + 1'b1;
			end
			if (do_step) begin
				expect_q <= expect_q + 1'b1;
				if (held_q != '0) begin
					held_q <= held_q - 1'b1;
				end
			end
			if (state_q == S_P_EOFEND && eof_ok_q) begin
				end_known_q <= 1'b1;
			end
			if (do_set_end) begin
				end_q <= seg_end_q;
			end
			if (do_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= stream_index;
			seg_end_q <= stream_index + IDX_W'(byte_present);
			data_q    <= data_byte;
			present_q <= byte_present;
			last_q    <= last_of_segment;
			eof_q     <= eof_flag;
			status_q  <= ST_NONE;
			rbyte_q   <= '0;
			rvalid_q  <= 1'b0;
		end
		unique case (state_q)
			S_P_WIN:    win_q    <= ofs_res.diff;
			S_P_END:    endoff_q <= ofs_res.diff;
			S_P_OFF:    inwin_q  <= ofs_res.lt;
			S_P_CHK:    status_q <= chk_status;
			S_P_EOF:    eof_ok_q <= ofs_res.le;
			S_R_POP:    rvalid_q <= do_pop;
			S_R_DATA:   rbyte_q  <= ring_rdata;
			default: begin
			end
		endcase
		if (do_load) begin
			out_status_q <= status_q;
			out_rbyte_q  <= rbyte_q;
			out_rvalid_q <= rvalid_q;
			out_expect_q <= expect_q;
			out_held_q   <= held_q;
			out_ended_q  <= end_known_q && (expect_q == end_q);
		end
	end

	assign out_valid         = out_valid_q;
	assign byte_status       = out_status_q;
	assign read_byte         = out_rbyte_q;
	assign read_valid        = out_rvalid_q;
	assign next_expected     = out_expect_q;
	assign unassembled_count = out_held_q;
	assign stream_ended      = out_ended_q;

	// The expected index never runs ahead of the window.
	a_expect_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(expect_q - read_q) <= CAP_IDX)
		else $error("expected index left the window");

	// A known end never lies behind the expected index or more than CAPACITY past it.
	a_end_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		end_known_q |-> ((end_q - expect_q) <= CAP_IDX))
		else $error("stream end outside range");

	// The held count cannot exceed the ring size.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(CAPACITY))
		else $error("held count exceeds capacity");

	// A result appears only when an item has finished.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without finished item");

	// A pop moves the read index by exactly one.
	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (read_q == $past(read_q) + 1'b1) && (rlim_q == read_q + CAP_IDX))
		else $error("read index step broken");

endmodule

### verif/bsr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsr_checker: result predictor and comparator for the stream reassembler
// Keeps its own copy of the byte ring, valid marks and stream pointers,
// works out the result of every accepted input item and compares each
// accepted result item field by field, in order.
// ----------------------------------------------------------------------------
module bsr_checker
	import bsr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,

	input  logic          in_valid,
	input  logic          in_stall,
	input  logic          command,
	input  idx_t          stream_index,
	input  logic [7:0]    data_byte,
	input  logic          byte_present,
	input  logic          last_of_segment,
	input  logic          eof_flag,

	input  logic          out_valid,
	input  logic          out_stall,
	input  logic [1:0]    byte_status,
	input  logic [7:0]    read_byte,
	input  logic          read_valid,
	input  idx_t          next_expected,
	input  cnt_t          unassembled_count,
	input  logic          stream_ended,

	output int            fail_count,
	output int            results_due,
	output idx_t          model_expect,
	output idx_t          model_read
);

	typedef struct {
		status_t    status;
		logic [7:0] rbyte;
		logic       rvalid;
		idx_t       next_exp;
		cnt_t       count;
		logic       ended;
	} reply_t;

	logic [7:0]  ring_data [CAPACITY];
	logic        ring_mark [CAPACITY];
	idx_t        rd_ptr;
	idx_t        asm_ptr;
	idx_t        end_ptr;
	logic        end_seen;
	int unsigned held_bytes;

	reply_t      stream_results_q [$];

	function automatic int unsigned ring_slot(idx_t i);
		return i % CAP_IDX;
	endfunction

	// Applies one item to the local copy of the reassembler state.
	function automatic reply_t reassemble_item(cmd_t cmd, idx_t idx, logic [7:0] data,
	                                           logic present, logic last, logic eof);
		reply_t      r;
		idx_t        room;
		idx_t        off;
		idx_t        seg_end;
		idx_t        seg_dist;
		int unsigned s;
		logic        keep;
		logic        walking;

		r.status = ST_NONE;
		r.rbyte  = 8'h00;
		r.rvalid = 1'b0;
		if (cmd == CMD_READ) begin
			if (rd_ptr != asm_ptr) begin
				s = ring_slot(rd_ptr);
				r.rbyte = ring_data[s];
				r.rvalid = 1'b1;
				ring_mark[s] = 1'b0;
				rd_ptr = rd_ptr + 1;
			end
		end else begin
			room = rd_ptr + CAP_IDX - asm_ptr;
			if (present) begin
				off  = idx - asm_ptr;
				keep = (off < room);
				if (end_seen && off >= idx_t'(end_ptr - asm_ptr))
					keep = 1'b0;
				if (!keep) begin
					r.status = ST_DROP;
				end else begin
					s = ring_slot(idx);
					if (ring_mark[s]) begin
						r.status = ST_DUP;
					end else begin
						ring_data[s] = data;
						ring_mark[s] = 1'b1;
						held_bytes++;
						r.status = ST_NEW;
					end
				end
			end
			if (last && eof) begin
				seg_end  = present ? idx + 1 : idx;
				seg_dist = seg_end - asm_ptr;
				// The nearer of two known ends wins.
				if (seg_dist <= room) begin
					if (!end_seen || seg_dist < idx_t'(end_ptr - asm_ptr))
						end_ptr = seg_end;
					end_seen = 1'b1;
				end
			end
		end

		walking = 1'b1;
		while (walking) begin
			if (idx_t'(asm_ptr - rd_ptr) >= CAP_IDX)
				walking = 1'b0;
			else if (end_seen && asm_ptr == end_ptr)
				walking = 1'b0;
			else if (!ring_mark[ring_slot(asm_ptr)])
				walking = 1'b0;
			else begin
				if (held_bytes != 0)
					held_bytes--;
				asm_ptr = asm_ptr + 1;
			end
		end

		r.next_exp = asm_ptr;
		r.count    = cnt_t'(held_bytes);
		r.ended    = end_seen && (asm_ptr == end_ptr);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			foreach (ring_mark[i]) begin
				ring_mark[i] = 1'b0;
				ring_data[i] = 8'h00;
			end
			rd_ptr     = '0;
			asm_ptr    = '0;
			end_ptr    = '0;
			end_seen   = 1'b0;
			held_bytes = 0;
			fail_count = 0;
			stream_results_q.delete();
			model_expect <= '0;
			model_read   <= '0;
			results_due  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (stream_results_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result item with no prediction waiting", $realtime);
				end else begin
					want = stream_results_q.pop_front();
					if (byte_status !== want.status || read_byte !== want.rbyte ||
					    read_valid !== want.rvalid || next_expected !== want.next_exp ||
					    unassembled_count !== want.count || stream_ended !== want.ended) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch, expected st=%0d byte=%02h rv=%0b next=%08h cnt=%0d end=%0b",
							         $realtime, want.status, want.rbyte, want.rvalid,
							         want.next_exp, want.count, want.ended);
							$display("%0t:               got st=%0d byte=%02h rv=%0b next=%08h cnt=%0d end=%0b",
							         $realtime, byte_status, read_byte, read_valid,
							         next_expected, unassembled_count, stream_ended);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				stream_results_q.push_back(reassemble_item(cmd_t'(command), stream_index,
				                                           data_byte, byte_present,
				                                           last_of_segment, eof_flag));
			model_expect <= asm_ptr;
			model_read   <= rd_ptr;
			results_due  <= stream_results_q.size();
		end
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of byte_stream_reassembler_core
// Drives push and read items with random gaps and result stalls, first a
// few hand-picked cases, then random segments, reads and noise, and at the
// end a closing sequence around the end of stream. Checking is done by
// bsr_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import bsr_pkg::*;

	// Longest stretch without any handshake in a correct run is the clearing
	// pass after reset or one item whose drain walks the whole ring. The limit
	// leaves plenty of margin.
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int RANDOM_ITEMS   = 1100;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       command = 1'b0;
	idx_t       stream_index = '0;
	logic [7:0] data_byte = 8'h00;
	logic       byte_present = 1'b0;
	logic       last_of_segment = 1'b0;
	logic       eof_flag = 1'b0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] byte_status;
	logic [7:0] read_byte;
	logic       read_valid;
	idx_t       next_expected;
	cnt_t       unassembled_count;
	logic       stream_ended;

	int         fail_count;
	int         results_due;
	idx_t       model_expect;
	idx_t       model_read;

	// When quiet is set, neither side inserts gaps or stalls.
	logic       quiet = 1'b0;
	int         items_sent = 0;
	int         idle_cycles = 0;
	int         recv_wait = 0;

	always #10 clk = ~clk;

	byte_stream_reassembler_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.stream_index      (stream_index),
		.data_byte         (data_byte),
		.byte_present      (byte_present),
		.last_of_segment   (last_of_segment),
		.eof_flag          (eof_flag),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.byte_status       (byte_status),
		.read_byte         (read_byte),
		.read_valid        (read_valid),
		.next_expected     (next_expected),
		.unassembled_count (unassembled_count),
		.stream_ended      (stream_ended)
	);

	bsr_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.stream_index      (stream_index),
		.data_byte         (data_byte),
		.byte_present      (byte_present),
		.last_of_segment   (last_of_segment),
		.eof_flag          (eof_flag),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.byte_status       (byte_status),
		.read_byte         (read_byte),
		.read_valid        (read_valid),
		.next_expected     (next_expected),
		.unassembled_count (unassembled_count),
		.stream_ended      (stream_ended),
		.fail_count        (fail_count),
		.results_due       (results_due),
		.model_expect      (model_expect),
		.model_read        (model_read)
	);

	// Result side: after every accepted result item a new stall length is
	// drawn, and the stall is held for that many cycles. The stall does not
	// look at out_valid, so it also lands on cycles where the block is busy.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			recv_wait = quiet ? 0 : $urandom_range(11, 0);
		else if (recv_wait > 0)
			recv_wait--;
		out_stall <= (recv_wait > 0);
	end

	// Watchdog: counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("byte_stream_reassembler_core test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Presents one item and returns at the edge where it is accepted. Valid
	// is only lowered when a gap follows, so back-to-back items keep it high.
	task automatic send_item(cmd_t cmd, idx_t idx, logic [7:0] data,
	                         logic present, logic last, logic eof);
		int gap;
		gap = quiet ? 0 : $urandom_range(11, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		command         <= cmd;
		stream_index    <= idx;
		data_byte       <= data;
		byte_present    <= present;
		last_of_segment <= last;
		eof_flag        <= eof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_push(idx_t idx, logic [7:0] data, logic present, logic last,
	                         logic eof);
		send_item(CMD_PUSH, idx, data, present, last, eof);
	endtask

	// The payload of a read item is ignored, so it is filled with noise.
	task automatic send_read();
		send_item(CMD_READ, $urandom, 8'($urandom), 1'($urandom_range(1, 0)),
		          1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
	endtask

	// Pushes the bytes [start, start+len) in shuffled order, with a few
	// repeats mixed in. The segment is closed either by its highest byte or
	// by an empty item at start+len; eof, when asked for, goes on the closing item.
	task automatic send_segment(idx_t start, int len, logic eof, logic empty_tail);
		int         order [$];
		logic [7:0] seg_bytes [$];
		int         k;
		int         j;
		int         tmp;
		logic       closing;

		for (k = 0; k < len; k++) begin
			order.push_back(k);
			seg_bytes.push_back(8'($urandom_range(255, 0)));
		end
		for (k = len - 1; k > 0; k--) begin
			j = $urandom_range(k, 0);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		// When the last byte closes the segment it has to be the highest one,
		// since the segment end is taken from the closing item.
		if (!empty_tail && len > 0) begin
			for (k = 0; k < len; k++) begin
				if (order[k] == len - 1) begin
					order[k] = order[len - 1];
					order[len - 1] = len - 1;
				end
			end
		end
		for (k = 0; k < len; k++) begin
			closing = !empty_tail && (k == len - 1);
			send_push(start + order[k], seg_bytes[order[k]], 1'b1, closing, eof && closing);
			if (!closing && $urandom_range(7, 0) == 0)
				send_push(start + order[$urandom_range(k, 0)], 8'($urandom_range(255, 0)),
				          1'b1, 1'b0, 1'b0);
		end
		if (empty_tail || len == 0)
			send_push(start + len, 8'($urandom_range(255, 0)), 1'b0, 1'b1, eof);
	endtask

	initial begin
		idx_t exp_now;
		idx_t rd_now;
		idx_t base;
		int   room;
		int   roll;
		int   len;
		int   offset;
		int   n;
		logic fill_phase;

		fill_phase = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// ---- Opening cases, starting from an empty ring at index zero ----
		send_read();                                       // nothing assembled yet
		send_push(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 1'b0); // far behind: dropped
		send_push(32'd1, 8'h00, 1'b1, 1'b0, 1'b0);         // held, not contiguous
		send_push(32'd1, 8'hAA, 1'b1, 1'b0, 1'b0);         // repeat keeps old value
		send_push(32'd0, 8'hFF, 1'b1, 1'b1, 1'b0);         // fills the gap, drains two
		send_push(CAP_IDX - 1, 8'h5A, 1'b1, 1'b0, 1'b0);   // top slot of the window
		send_push(CAP_IDX, 8'hA5, 1'b1, 1'b0, 1'b0);       // just past the window
		send_push(32'd5, 8'h00, 1'b0, 1'b1, 1'b0);         // empty segment end
		send_push(32'h8000_0000, 8'h00, 1'b0, 1'b1, 1'b1); // end far out: not taken
		send_push(32'd2, 8'h55, 1'b1, 1'b0, 1'b1);         // eof without last: ignored
		repeat (3) send_read();                            // pops FF, 00, 55
		send_read();                                       // caught up: nothing
		send_push(32'd0, 8'h12, 1'b1, 1'b1, 1'b0);         // below expected: dropped

		// ---- Random part ----
		// Mostly well-formed segments near the expected index, some segments
		// that run past the window, reads that pop a random share of what is
		// assembled, and noise with arbitrary indices. During a fill phase the
		// reads almost stop, so the window runs full and drops pile up. The
		// reads still needed to empty the ring count toward the item budget.
		while (items_sent + int'(idx_t'(model_expect - model_read)) < RANDOM_ITEMS - 40) begin
			exp_now = model_expect;
			rd_now  = model_read;
			room    = int'(idx_t'(rd_now + CAP_IDX - exp_now));
			if ($urandom_range(39, 0) == 0) begin
				quiet      <= ($urandom_range(2, 0) == 0);
				fill_phase = ($urandom_range(3, 0) == 0);
			end
			roll = $urandom_range(99, 0);
			if (roll < 50) begin
				len    = $urandom_range(16, 1);
				offset = $urandom_range(48, 0);
				send_segment(exp_now + offset, len, 1'b0, 1'($urandom_range(1, 0)));
			end else if (roll < 60) begin
				// An eof here is only set when the segment end lies well past
				// the window, so the stream is never closed by accident.
				len    = $urandom_range(16, 1);
				offset = $urandom_range(room + 96, 0);
				send_segment(exp_now + offset, len,
				             (offset + len > room + 64) && $urandom_range(1, 0),
				             1'($urandom_range(1, 0)));
			end else if (roll < 85) begin
				if (fill_phase)
					n = $urandom_range(1, 0);
				else
					n = $urandom_range(int'(idx_t'(exp_now - rd_now)) + 2, 1);
				repeat (n) send_read();
			end else if (roll < 95) begin
				send_push($urandom, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
				          1'($urandom_range(1, 0)), 1'b0);
			end else begin
				send_push(exp_now + 32'h8000_0000 + $urandom_range(65535, 0),
				          8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1, 1'b1);
			end
		end

		// ---- Closing cases around the end of stream ----
		// Empty the ring first so the whole window lies ahead of the base.
		// One edge lets the model pointers take in the last random item.
		quiet <= 1'b0;
		@(posedge clk);
		while (model_read != model_expect)
			send_read();
		base = model_expect;
		send_push(base + 20, 8'h3C, 1'b1, 1'b0, 1'b0);     // held beyond the coming end
		send_push(base + 21, 8'hC3, 1'b1, 1'b0, 1'b0);
		send_push(base + CAP_IDX, 8'h00, 1'b0, 1'b1, 1'b1); // end at the window edge
		send_push(base + 7, 8'h77, 1'b1, 1'b1, 1'b1);       // nearer end replaces it
		send_push(base + 12, 8'h00, 1'b0, 1'b1, 1'b1);      // farther end is ignored
		send_push(base + 8, 8'h88, 1'b1, 1'b0, 1'b0);       // at the end: dropped
		send_push(base + 7, 8'h11, 1'b1, 1'b0, 1'b0);       // repeat of a held byte
		send_segment(base, 7, 1'b0, 1'b0);                  // completes the stream
		repeat (3) send_read();
		send_push(base + 1, 8'hEE, 1'b1, 1'b1, 1'b0);       // after the end: dropped
		while (model_read != model_expect)
			send_read();
		send_read();

		in_valid <= 1'b0;
		while (results_due != 0)
			@(posedge clk);
		// One item can walk the whole ring, so allow that much for stragglers.
		repeat (CAPACITY + 64) @(posedge clk);

		if (fail_count == 0)
			$display("byte_stream_reassembler_core test passed");
		else
			$display("byte_stream_reassembler_core test failed");
		$finish;
	end

endmodule
